// ----- hw/rtl/bdrl_pkg.sv -----
package bdrl_pkg;

    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int MIN_W    = 16;
    localparam int WIN_W    = 24;
    localparam int MAX_W    = 8;
    localparam int CNT_W    = 8;
    localparam int MASK_W   = 8;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_BUTTONS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_WIN  = 3'd4;

    localparam logic             RST_ACTIVE_LOW   = 1'b1;
    localparam logic [DEB_W-1:0] RST_DEBOUNCE     = 16'd50;
    localparam logic [MIN_W-1:0] RST_MIN_INTERVAL = 16'd1000;
    localparam logic [WIN_W-1:0] RST_WINDOW       = 24'd60000;
    localparam logic [MAX_W-1:0] RST_MAX_PER_WIN  = 8'd10;

    typedef struct packed {
        logic             active_low;
        logic [DEB_W-1:0] debounce_ms;
        logic [MIN_W-1:0] min_interval_ms;
        logic [WIN_W-1:0] window_ms;
        logic [MAX_W-1:0] max_per_window;
    } t_cfg;

    typedef struct packed {
        logic accepted;
        logic limited;
        logic pressed;
    } t_lane_res;

    typedef struct packed {
        logic [MASK_W-1:0] accepted_mask;
        logic [MASK_W-1:0] limited_mask;
        logic [MASK_W-1:0] pressed_mask;
    } t_beat;

endpackage

// ----- hw/rtl/bdrl_lane.sv -----
module bdrl_lane
    import bdrl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_reading,
    input  logic [TIME_W-1:0] i_now,
    input  t_cfg              i_cfg,
    output t_lane_res         o_res
);

    logic              r_last_raw, n_last_raw;
    logic              r_stable, n_stable;
    logic              r_pressed, n_pressed;
    logic [TIME_W-1:0] r_chg_time, n_chg_time;
    logic [TIME_W-1:0] r_acc_time, n_acc_time;
    logic [TIME_W-1:0] r_win_start, n_win_start;
    logic [CNT_W-1:0]  r_win_cnt, n_win_cnt;

    logic              chg, settle, active, press, release_det;
    logic              gap_ok, win_old, pass;
    logic [TIME_W-1:0] since_chg, gap, since_win;
    logic [CNT_W-1:0]  cnt_eff;

    always_comb begin
        chg       = i_reading != r_last_raw;
        since_chg = i_now - r_chg_time;
        // a fresh edge restarts the timer, so it can never settle on this beat
        settle    = !chg && (since_chg > {{(TIME_W-DEB_W){1'b0}}, i_cfg.debounce_ms})
                    && (i_reading != r_stable);
        active    = i_cfg.active_low ? !i_reading : i_reading;
        press       = settle && active && !r_pressed;
        release_det = settle && !active && r_pressed;

        gap       = i_now - r_acc_time;
        gap_ok    = !(gap < {{(TIME_W-MIN_W){1'b0}}, i_cfg.min_interval_ms});
        since_win = i_now - r_win_start;
        win_old   = since_win >= {{(TIME_W-WIN_W){1'b0}}, i_cfg.window_ms};
        cnt_eff   = win_old ? '0 : r_win_cnt;
        pass      = gap_ok && (cnt_eff < i_cfg.max_per_window);

        n_last_raw  = i_reading;
        n_chg_time  = chg ? i_now : r_chg_time;
        n_stable    = settle ? i_reading : r_stable;
        n_pressed   = press ? 1'b1 : (release_det ? 1'b0 : r_pressed);
        n_acc_time  = r_acc_time;
        n_win_start = r_win_start;
        n_win_cnt   = r_win_cnt;
        // window restart happens only once the min-interval check passed
        if (press && gap_ok) begin
            if (win_old) begin
                n_win_start = i_now;
            end
            n_win_cnt = pass ? cnt_eff + 1'b1 : cnt_eff;
            if (pass) begin
                n_acc_time = i_now;
            end
        end

        o_res.accepted = press && pass;
        o_res.limited  = press && !pass;
        o_res.pressed  = n_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b1;
            r_stable    <= 1'b1;
            r_pressed   <= 1'b0;
            r_chg_time  <= '0;
            r_acc_time  <= '0;
            r_win_start <= '0;
            r_win_cnt   <= '0;
        end else if (i_fire) begin
            r_last_raw  <= n_last_raw;
            r_stable    <= n_stable;
            r_pressed   <= n_pressed;
            r_chg_time  <= n_chg_time;
            r_acc_time  <= n_acc_time;
            r_win_start <= n_win_start;
            r_win_cnt   <= n_win_cnt;
        end
    end

endmodule

// ----- hw/rtl/bdrl_merge.sv -----
module bdrl_merge
    import bdrl_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_lane_res         i_lane [NUM_BUTTONS],
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [MASK_W-1:0] o_accepted_mask,
    output logic [MASK_W-1:0] o_limited_mask,
    output logic [MASK_W-1:0] o_pressed_mask,
    output logic              o_full
);

    t_beat      beat;
    t_beat      r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_cnt;
    logic       pop;

    // lanes past the mask width keep running but never show in the beat
    for (genvar i = 0; i < MASK_W; i++) begin : g_mask
        if (i < NUM_BUTTONS) begin : g_on
            assign beat.accepted_mask[i] = i_lane[i].accepted;
            assign beat.limited_mask[i]  = i_lane[i].limited;
            assign beat.pressed_mask[i]  = i_lane[i].pressed;
        end else begin : g_off
            assign beat.accepted_mask[i] = 1'b0;
            assign beat.limited_mask[i]  = 1'b0;
            assign beat.pressed_mask[i]  = 1'b0;
        end
    end

    assign o_out_valid     = r_cnt != 2'd0;
    assign o_full          = r_cnt == 2'd2;
    assign pop             = o_out_valid && !i_out_stall;
    assign o_accepted_mask = r_q[r_rd_ptr].accepted_mask;
    assign o_limited_mask  = r_q[r_rd_ptr].limited_mask;
    assign o_pressed_mask  = r_q[r_rd_ptr].pressed_mask;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ----- hw/rtl/button_debounce_rate_limiter.sv -----
// channel | valid        | stall        | payload
// --------+--------------+--------------+--------------------------------------------
// in      | i_in_valid   | o_in_stall   | i_button_levels, i_now_ms
// out     | o_out_valid  | i_out_stall  | o_accepted_mask, o_limited_mask, o_pressed_mask
// cfg     | i_cfg_wr_en  | -            | i_cfg_index, i_cfg_data
//
// One beat per cycle while o_in_stall is low: every button lane updates its debounce
// and rate-limit state in the cycle the beat is taken, and the merged masks are
// registered in a two-entry output queue that decouples the sides; o_in_stall rises
// only when both entries wait. Synchronous reset loads default config, raw/stable
// levels to 1, all timers and counters to zero.
module button_debounce_rate_limiter
    import bdrl_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MASK_W-1:0]    i_button_levels,
    input  logic [TIME_W-1:0]    i_now_ms,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [MASK_W-1:0]    o_accepted_mask,
    output logic [MASK_W-1:0]    o_limited_mask,
    output logic [MASK_W-1:0]    o_pressed_mask,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg      r_cfg;
    t_lane_res lane_res [NUM_BUTTONS];
    logic      fire;
    logic      full;

    assign o_in_stall = full;
    assign fire       = i_in_valid && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low      <= RST_ACTIVE_LOW;
            r_cfg.debounce_ms     <= RST_DEBOUNCE;
            r_cfg.min_interval_ms <= RST_MIN_INTERVAL;
            r_cfg.window_ms       <= RST_WINDOW;
            r_cfg.max_per_window  <= RST_MAX_PER_WIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW:   r_cfg.active_low      <= i_cfg_data[0];
                CFG_DEBOUNCE:     r_cfg.debounce_ms     <= i_cfg_data[DEB_W-1:0];
                CFG_MIN_INTERVAL: r_cfg.min_interval_ms <= i_cfg_data[MIN_W-1:0];
                CFG_WINDOW:       r_cfg.window_ms       <= i_cfg_data[WIN_W-1:0];
                CFG_MAX_PER_WIN:  r_cfg.max_per_window  <= i_cfg_data[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
        logic reading;
        // buttons past the input width always read low
        if (b < MASK_W) begin : g_pin
            assign reading = i_button_levels[b];
        end else begin : g_tie
            assign reading = 1'b0;
        end

        bdrl_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_fire    (fire),
            .i_reading (reading),
            .i_now     (i_now_ms),
            .i_cfg     (r_cfg),
            .o_res     (lane_res[b])
        );
    end

    bdrl_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (fire),
        .i_lane          (lane_res),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_accepted_mask (o_accepted_mask),
        .o_limited_mask  (o_limited_mask),
        .o_pressed_mask  (o_pressed_mask),
        .o_full          (full)
    );

endmodule

// ----- sim/button_debounce_rate_limiter_test.sv -----
`timescale 1ns / 1ps

module button_debounce_rate_limiter_test;
    import bdrl_pkg::*;

    localparam int NUM_LANES = NUM_BUTTONS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [MASK_W-1:0]    i_button_levels;
    logic [TIME_W-1:0]    i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [MASK_W-1:0]    o_accepted_mask;
    logic [MASK_W-1:0]    o_limited_mask;
    logic [MASK_W-1:0]    o_pressed_mask;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    button_debounce_rate_limiter i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_button_levels (i_button_levels),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted_mask (o_accepted_mask),
        .o_limited_mask  (o_limited_mask),
        .o_pressed_mask  (o_pressed_mask),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block: config and per-button lane state
    t_cfg              cfg_shadow;
    logic              raw_q     [NUM_LANES];
    logic              stable_q  [NUM_LANES];
    logic              pressed_q [NUM_LANES];
    logic [TIME_W-1:0] change_t  [NUM_LANES];
    logic [TIME_W-1:0] accept_t  [NUM_LANES];
    logic [TIME_W-1:0] win_start [NUM_LANES];
    logic [CNT_W-1:0]  win_cnt   [NUM_LANES];

    t_beat             expected_beats [$];
    t_beat             want;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                hold_req = 0;
    bit                no_idle = 1'b0;
    logic [TIME_W-1:0] last_now = '0;
    logic [MASK_W-1:0] last_levels = '1;

    task automatic lanes_reset();
        cfg_shadow = '{active_low: RST_ACTIVE_LOW, debounce_ms: RST_DEBOUNCE,
                       min_interval_ms: RST_MIN_INTERVAL, window_ms: RST_WINDOW,
                       max_per_window: RST_MAX_PER_WIN};
        for (int b = 0; b < NUM_LANES; b++) begin
            raw_q[b]     = 1'b1;
            stable_q[b]  = 1'b1;
            pressed_q[b] = 1'b0;
            change_t[b]  = '0;
            accept_t[b]  = '0;
            win_start[b] = '0;
            win_cnt[b]   = '0;
        end
    endtask

    function automatic t_beat debounce_step(input logic [MASK_W-1:0] levels,
                                            input logic [TIME_W-1:0] now);
        t_beat             res;
        logic              rd;
        logic              active;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] since_acc;
        logic [TIME_W-1:0] since_win;
        res = '0;
        for (int b = 0; b < NUM_LANES; b++) begin
            rd = levels[b];
            if (rd != raw_q[b])
                change_t[b] = now;
            held = now - change_t[b];
            if (held > TIME_W'(cfg_shadow.debounce_ms) && rd != stable_q[b]) begin
                active = cfg_shadow.active_low ? !rd : rd;
                stable_q[b] = rd;
                if (active && !pressed_q[b]) begin
                    pressed_q[b] = 1'b1;
                    since_acc = now - accept_t[b];
                    since_win = now - win_start[b];
                    if (since_acc < TIME_W'(cfg_shadow.min_interval_ms)) begin
                        res.limited_mask[b] = 1'b1;
                    end else begin
                        if (since_win >= TIME_W'(cfg_shadow.window_ms)) begin
                            win_start[b] = now;
                            win_cnt[b]   = '0;
                        end
                        if (win_cnt[b] >= cfg_shadow.max_per_window) begin
                            res.limited_mask[b] = 1'b1;
                        end else begin
                            accept_t[b] = now;
                            win_cnt[b]  = win_cnt[b] + 1'b1;
                            res.accepted_mask[b] = 1'b1;
                        end
                    end
                end else if (!active && pressed_q[b]) begin
                    pressed_q[b] = 1'b0;
                end
            end
            raw_q[b] = rd;
            res.pressed_mask[b] = pressed_q[b];
        end
        return res;
    endfunction

    function automatic t_cfg make_cfg(input logic al, input logic [DEB_W-1:0] deb,
                                      input logic [MIN_W-1:0] min_gap,
                                      input logic [WIN_W-1:0] win,
                                      input logic [MAX_W-1:0] max_cnt);
        return '{active_low: al, debounce_ms: deb, min_interval_ms: min_gap,
                 window_ms: win, max_per_window: max_cnt};
    endfunction

    // writes every register back to back, with junk in the unused upper bits,
    // plus one write to an unmapped index
    task automatic write_config(input t_cfg c);
        logic [CFG_W-1:0]     junk;
        logic [CFG_W-1:0]     data;
        logic [CFG_IDX_W-1:0] idx;
        for (int k = 0; k < 6; k++) begin
            junk = CFG_W'($urandom);
            unique case (k)
                0: begin
                    idx  = CFG_ACTIVE_LOW;
                    data = {junk[CFG_W-1:1], c.active_low};
                end
                1: begin
                    idx  = CFG_DEBOUNCE;
                    data = {junk[CFG_W-1:DEB_W], c.debounce_ms};
                end
                2: begin
                    idx  = CFG_MIN_INTERVAL;
                    data = {junk[CFG_W-1:MIN_W], c.min_interval_ms};
                end
                3: begin
                    idx  = CFG_WINDOW;
                    data = c.window_ms;
                end
                4: begin
                    idx  = CFG_MAX_PER_WIN;
                    data = {junk[CFG_W-1:MAX_W], c.max_per_window};
                end
                default: begin
                    idx  = CFG_UNUSED;
                    data = junk;
                end
            endcase
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data;
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg_shadow = c;
    endtask

    task automatic send_beat(input logic [MASK_W-1:0] levels, input logic [TIME_W-1:0] now);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_button_levels <= levels;
        i_now_ms        <= now;
        do @(posedge i_clk); while (o_in_stall);
        last_now    = now;
        last_levels = levels;
        expected_beats.push_back(debounce_step(levels, now));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // default config: presses close to time zero get refused
    task automatic test_reset_defaults();
        send_beat(8'hFF, 32'd0);
        send_beat(8'hFE, 32'd10);
        send_beat(8'hFE, 32'd61);
        send_beat(8'hFF, 32'd70);
        send_beat(8'hFF, 32'd121);
        send_beat(8'h00, 32'd200);
        send_beat(8'h00, 32'd1300);
        send_beat(8'hFF, 32'd1400);
        send_beat(8'hFF, 32'hFFFF_FFF0);
    endtask

    // polarity flip leaves stored levels alone
    task automatic test_polarity_switch();
        drain_results();
        write_config(make_cfg(1'b0, 16'd0, 16'd0, 24'hFF_FFFF, 8'd255));
        send_beat(8'hFF, 32'hFFFF_FFF8);
        send_beat(8'h00, 32'hFFFF_FFFC);
        send_beat(8'h00, 32'd2);
        send_beat(8'hA5, 32'd3);
        send_beat(8'hA5, 32'd5);
        drain_results();
        write_config(make_cfg(1'b1, 16'd0, 16'd0, 24'hFF_FFFF, 8'd255));
        send_beat(8'hA5, 32'd7);
        send_beat(8'h00, 32'd9);
        send_beat(8'h00, 32'd11);
    endtask

    task automatic test_config_extremes();
        drain_results();
        write_config(make_cfg(1'b1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF));
        send_beat(8'hFF, 32'd20);
        send_beat(8'h5A, 32'd30);
        send_beat(8'h5A, 32'd65565);
        send_beat(8'h5A, 32'd65566);
        drain_results();
        // max of zero refuses everything, window of zero restarts every press
        write_config(make_cfg(1'b0, 16'd0, 16'd0, 24'd0, 8'd0));
        send_beat(8'h00, 32'h8000_0000);
        send_beat(8'h00, 32'h8000_0001);
        send_beat(8'hFF, 32'h8000_0002);
        send_beat(8'hFF, 32'h8000_0003);
    endtask

    // steps scale with the config so that debounce and rate limits are hit
    task automatic test_random_traffic(input t_cfg c, input int n_items);
        logic [MASK_W-1:0] lv;
        logic [TIME_W-1:0] step;
        int                pick;
        int                bit_idx;
        drain_results();
        write_config(c);
        lv = last_levels;
        for (int k = 0; k < n_items; k++) begin
            no_idle = (k % 100) >= 70;
            pick = $urandom_range(0, 99);
            if (pick < 10)
                step = '0;
            else if (pick < 50)
                step = $urandom_range(0, c.debounce_ms + 2);
            else if (pick < 85)
                step = $urandom_range(0, c.min_interval_ms + c.debounce_ms + 10);
            else if (pick < 95)
                step = $urandom_range(0, c.window_ms + 10);
            else
                step = $urandom;
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                bit_idx = $urandom_range(0, MASK_W - 1);
                lv[bit_idx] = ~lv[bit_idx];
            end else if (pick == 3) begin
                lv = MASK_W'($urandom);
            end
            send_beat(lv, last_now + step);
        end
        no_idle = 1'b0;
    endtask

    // sink holds off while beats keep coming, so the input must stall
    task automatic test_output_backpressure();
        drain_results();
        no_idle  = 1'b1;
        hold_req = 48;
        for (int k = 0; k < 14; k++)
            send_beat(MASK_W'($urandom), last_now + $urandom_range(0, 120));
        no_idle = 1'b0;
    endtask

    initial begin : result_sink
        int wait_cycles;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req != 0) begin
                wait_cycles = hold_req;
                hold_req = 0;
            end else begin
                wait_cycles = no_idle ? 0 : $urandom_range(0, 8);
            end
            i_out_stall <= (wait_cycles != 0);
            if (wait_cycles != 0) begin
                repeat (wait_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (o_accepted_mask !== want.accepted_mask) begin
                    $error("accepted_mask: expected %h, got %h",
                           want.accepted_mask, o_accepted_mask);
                    fail_count++;
                end
                if (o_limited_mask !== want.limited_mask) begin
                    $error("limited_mask: expected %h, got %h",
                           want.limited_mask, o_limited_mask);
                    fail_count++;
                end
                if (o_pressed_mask !== want.pressed_mask) begin
                    $error("pressed_mask: expected %h, got %h",
                           want.pressed_mask, o_pressed_mask);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("button_debounce_rate_limiter test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_button_levels <= '1;
        i_now_ms        <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        lanes_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_polarity_switch();
        test_config_extremes();
        test_random_traffic(make_cfg(1'b1, 16'd50, 16'd1000, 24'd60000, 8'd10), 280);
        test_random_traffic(make_cfg(1'b0, 16'd3, 16'd20, 24'd200, 8'd3), 280);
        test_random_traffic(make_cfg(1'b1, 16'd0, 16'd0, 24'd0, 8'd255), 280);
        test_output_backpressure();
        test_random_traffic(make_cfg(1'($urandom_range(0, 1)), DEB_W'($urandom_range(0, 80)),
                                     MIN_W'($urandom_range(0, 300)),
                                     WIN_W'($urandom_range(0, 3000)),
                                     MAX_W'($urandom_range(0, 6))), 280);
        test_random_traffic(make_cfg(1'b0, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 8'hFF), 200);
        test_random_traffic(make_cfg(1'($urandom_range(0, 1)), DEB_W'($urandom_range(0, 20)),
                                     MIN_W'($urandom_range(0, 100)),
                                     WIN_W'($urandom_range(0, 800)),
                                     MAX_W'($urandom_range(0, 4))), 280);

        drain_results();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("button_debounce_rate_limiter test passed");
        else
            $display("button_debounce_rate_limiter test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bdrl_pkg.sv
hw/rtl/bdrl_lane.sv
hw/rtl/bdrl_merge.sv
hw/rtl/button_debounce_rate_limiter.sv
sim/button_debounce_rate_limiter_test.sv
